// ===== rtl/core/cptd_pkg.sv =====
// Shared constants and helpers for the COBS position telemetry decoder.
// No dependencies; imported by the decoder top level.
`default_nettype none
package cptd_pkg;

    localparam int MAX_FRAME_DEF  = 15;
    localparam int POSITION_BYTES = 11;

    localparam logic [3:0] FULL_LEN  = 4'd14;
    localparam logic [7:0] FULL_CODE = 8'd8;
    localparam logic [3:0] IDX_MAX   = 4'd10;
    localparam logic [7:0] CODE_LONG = 8'hFF;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_COBS    = 3'd1;
    localparam logic [2:0] ST_LENGTH  = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_INDEX   = 3'd4;

    typedef logic [7:0] t_byte;

    // Decoded length required for a sparse frame carrying the given item count.
    function automatic logic [3:0] len_for_count(input logic [3:0] cnt);
        logic [3:0] len;
        case (cnt)
            4'd1:    len = 4'd4;
            4'd2:    len = 4'd6;
            4'd3:    len = 4'd7;
            4'd4:    len = 4'd9;
            4'd5:    len = 4'd10;
            4'd6:    len = 4'd12;
            4'd7:    len = 4'd13;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // Fletcher sum step modulo 255; both operands are below 256.
    function automatic t_byte mod255_add(input t_byte a, input t_byte b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 9'd255) begin
            s = s - 9'd255;
        end
        return s[7:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cptd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cptd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/cobs_position_telemetry_decoder.sv =====
// Top level of the COBS-framed position telemetry decoder.
// Depends on cptd_pkg and on cptd_ram for the encoded frame buffer.
`default_nettype none
// A payload byte that is not a frame end is written into the frame buffer RAM
// while the decoder is synced and the buffer has room. A zero byte that ends a
// frame starts the read-back: the buffer is read back one byte a cycle through its
// single read port while COBS decoding, the Fletcher-16 sums, the index checks and
// the staging of the new position all run on the decoded byte stream. A final
// state settles the status, commits a good position and puts the result in an
// output register, waiting while that register is full; input waits meanwhile.
module cobs_position_telemetry_decoder
    import cptd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_data_byte,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_status,
    output logic signed [31:0]      o_latitude,
    output logic signed [31:0]      o_longitude,
    output logic signed [23:0]      o_altitude
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int AW = $clog2(MAX_FRAME);
    localparam int EW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] FRAME_FULL = CW'(MAX_FRAME);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic          r_synced, n_synced;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [7:0]    r_rem, n_rem;
    logic [7:0]    r_prev_code, n_prev_code;
    logic          r_cobs_err, n_cobs_err;
    logic [3:0]    r_dpos, n_dpos;
    t_byte         r_s1, n_s1, r_s2, n_s2;
    t_byte         r_h0, n_h0, r_h1, n_h1;
    t_byte         r_hdr, n_hdr;
    logic [3:0]    r_last, n_last;
    logic          r_idx_bad, n_idx_bad;
    logic [3:0]    r_idx [0:7];
    logic [3:0]    n_idx [0:7];
    t_byte         r_temp [0:POSITION_BYTES-1];
    t_byte         n_temp [0:POSITION_BYTES-1];
    t_byte         r_store [0:POSITION_BYTES-1];
    t_byte         n_store [0:POSITION_BYTES-1];
    logic          r_o_valid, n_o_valid;
    logic [2:0]    r_status, n_status;
    logic [31:0]   r_lat, n_lat, r_lon, n_lon;
    logic [23:0]   r_alt, n_alt;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_byte         ram_rdata;
    logic          in_acc;

    cptd_ram #(
        .WIDTH(8),
        .DEPTH(MAX_FRAME)
    ) u_frame_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_data_byte),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        logic          emit;
        t_byte         em;
        logic          err_now;
        logic [CW-1:0] pos_inc;
        logic [EW-1:0] left;
        logic [EW-1:0] blk;
        logic [3:0]    numd;
        logic [3:0]    half;
        logic [3:0]    offs;
        logic [3:0]    rel;
        logic [2:0]    i_lo, i_hi;
        logic [3:0]    nib, idx;
        logic          sparse_ok;
        logic [2:0]    st;
        t_byte         sel [0:POSITION_BYTES-1];

        n_state     = r_state;
        n_synced    = r_synced;
        n_count     = r_count;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_prev_code = r_prev_code;
        n_cobs_err  = r_cobs_err;
        n_dpos      = r_dpos;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_h0        = r_h0;
        n_h1        = r_h1;
        n_hdr       = r_hdr;
        n_last      = r_last;
        n_idx_bad   = r_idx_bad;
        n_idx       = r_idx;
        n_temp      = r_temp;
        n_store     = r_store;
        n_o_valid   = r_o_valid;
        n_status    = r_status;
        n_lat       = r_lat;
        n_lon       = r_lon;
        n_alt       = r_alt;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_raddr   = '0;
        emit        = 1'b0;
        em          = '0;
        err_now     = 1'b0;
        pos_inc     = r_pos + 1'b1;
        left        = EW'(r_count - pos_inc);
        blk         = EW'(ram_rdata - 8'd1);
        numd        = r_hdr[3:0];
        half        = {1'b0, numd[3:1]};
        offs        = half + 4'd1;
        rel         = r_dpos - offs;
        i_lo        = {r_dpos[1:0], 1'b0} - 3'd1;
        i_hi        = {r_dpos[1:0], 1'b0};
        nib         = '0;
        idx         = '0;
        sparse_ok   = (numd >= 4'd1) && (numd <= 4'd7);
        st          = ST_OK;
        sel         = r_store;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!r_synced) begin
                        if (i_data_byte == 8'd0) begin
                            n_synced = 1'b1;
                            n_count  = '0;
                        end
                    end else if (i_data_byte != 8'd0) begin
                        if (r_count < FRAME_FULL) begin
                            ram_we  = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_synced = 1'b0;
                        end
                    end else begin
                        // Frame end: start the read-back at entry 0.
                        n_pos       = '0;
                        n_rem       = '0;
                        n_prev_code = '0;
                        n_cobs_err  = (r_count == '0);
                        n_dpos      = '0;
                        n_s1        = '0;
                        n_s2        = '0;
                        n_idx_bad   = 1'b0;
                        n_temp      = r_store;
                        n_state     = (r_count == '0) ? S_FIN : S_DEC;
                    end
                end
            end

            S_DEC: begin
                if (pos_inc < r_count) begin
                    ram_raddr = pos_inc[AW-1:0];
                end
                if (r_rem == 8'd0) begin
                    // Code byte; the zero owed by the previous block goes out now.
                    if (ram_rdata == 8'd0 || blk > left) begin
                        err_now = 1'b1;
                    end
                    n_rem       = ram_rdata - 8'd1;
                    n_prev_code = ram_rdata;
                    emit        = (r_pos != '0) && (r_prev_code != CODE_LONG);
                    em          = '0;
                end else begin
                    n_rem = r_rem - 8'd1;
                    emit  = 1'b1;
                    em    = ram_rdata;
                end

                if (err_now) begin
                    n_cobs_err = 1'b1;
                end

                if (emit && !err_now && !r_cobs_err) begin
                    if (r_dpos >= 4'd2) begin
                        n_s1 = mod255_add(r_s1, r_h1);
                        n_s2 = mod255_add(r_s2, n_s1);
                    end
                    n_h1 = r_h0;
                    n_h0 = em;
                    if (r_dpos != 4'd15) begin
                        n_dpos = r_dpos + 4'd1;
                    end

                    if (r_dpos == 4'd0) begin
                        n_hdr    = em;
                        nib      = em[7:4];
                        n_idx[0] = nib;
                        n_last   = nib;
                        if (nib > IDX_MAX) begin
                            n_idx_bad = 1'b1;
                        end
                    end else if (r_hdr == FULL_CODE) begin
                        if (r_dpos <= 4'(POSITION_BYTES)) begin
                            n_temp[r_dpos - 4'd1] = em;
                        end
                    end else if (sparse_ok) begin
                        if (r_dpos <= half) begin
                            // Index byte: low nibble first, then high nibble.
                            if ({1'b0, i_lo} < numd) begin
                                nib         = em[3:0];
                                n_idx[i_lo] = nib;
                                if (nib <= n_last || nib > IDX_MAX) begin
                                    n_idx_bad = 1'b1;
                                end
                                n_last = nib;
                            end
                            if ({1'b0, i_hi} < numd) begin
                                nib         = em[7:4];
                                n_idx[i_hi] = nib;
                                if (nib <= n_last || nib > IDX_MAX) begin
                                    n_idx_bad = 1'b1;
                                end
                                n_last = nib;
                            end
                        end else if (r_dpos >= offs && rel < numd) begin
                            idx = r_idx[rel[2:0]];
                            if (idx <= IDX_MAX) begin
                                n_temp[idx] = em;
                            end
                        end
                    end
                end

                if (pos_inc == r_count) begin
                    n_state = S_FIN;
                end else begin
                    n_pos = pos_inc;
                end
            end

            S_FIN: begin
                if (!r_o_valid || i_ready) begin
                    if (r_cobs_err) begin
                        st = ST_COBS;
                    end else if (r_hdr == FULL_CODE && r_dpos != FULL_LEN) begin
                        st = ST_LENGTH;
                    end else if (r_hdr != FULL_CODE && r_dpos == FULL_LEN) begin
                        st = ST_LENGTH;
                    end else if (r_hdr != FULL_CODE
                                 && (!sparse_ok || len_for_count(numd) != r_dpos)) begin
                        st = ST_LENGTH;
                    end else if (r_h1 != r_s1 || r_h0 != r_s2) begin
                        st = ST_CHECK;
                    end else if (r_hdr != FULL_CODE && r_idx_bad) begin
                        st = ST_INDEX;
                    end

                    if (st == ST_OK) begin
                        n_store = r_temp;
                        sel     = r_temp;
                        n_count = '0;
                    end else begin
                        n_synced = 1'b0;
                    end
                    n_o_valid = 1'b1;
                    n_status  = st;
                    n_lat     = {sel[3], sel[2], sel[1], sel[0]};
                    n_lon     = {sel[7], sel[6], sel[5], sel[4]};
                    n_alt     = {sel[10], sel[9], sel[8]};
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_synced  <= 1'b0;
            r_count   <= '0;
            r_hdr     <= '0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < POSITION_BYTES; k++) begin
                r_store[k] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_synced  <= n_synced;
            r_count   <= n_count;
            r_hdr     <= n_hdr;
            r_o_valid <= n_o_valid;
            r_store   <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_rem       <= n_rem;
        r_prev_code <= n_prev_code;
        r_cobs_err  <= n_cobs_err;
        r_dpos      <= n_dpos;
        r_s1        <= n_s1;
        r_s2        <= n_s2;
        r_h0        <= n_h0;
        r_h1        <= n_h1;
        r_last      <= n_last;
        r_idx_bad   <= n_idx_bad;
        r_idx       <= n_idx;
        r_temp      <= n_temp;
        r_status    <= n_status;
        r_lat       <= n_lat;
        r_lon       <= n_lon;
        r_alt       <= n_alt;
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_status;
    assign o_latitude  = r_lat;
    assign o_longitude = r_lon;
    assign o_altitude  = r_alt;

endmodule
`default_nettype wire
